### src/stt_pkg.sv
// Shared types, codes and defaults for the session table.
`default_nettype none

package stt_pkg;

    localparam int SESSIONS_DEF   = 8;
    localparam int ID_BITS_DEF    = 64;
    localparam int TOKEN_BITS_DEF = 64;

    localparam int TIME_W    = 48;
    localparam int FIELD_W   = 64;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] IDLE_TMO_RST = 32'd900000;
    localparam logic [CFG_W-1:0] ABS_TMO_RST  = 32'd86400000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TMO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ABS_TMO  = 1'b1;

    // Operation codes
    localparam logic [2:0] FN_CREATE = 3'd0;
    localparam logic [2:0] FN_CHECK  = 3'd1;
    localparam logic [2:0] FN_TOUCH  = 3'd2;
    localparam logic [2:0] FN_REVOKE = 3'd3;
    localparam logic [2:0] FN_READ   = 3'd4;
    localparam logic [2:0] FN_SWEEP  = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_COMMIT
    } stt_state_t;

    typedef struct packed {
        logic start;
        logic issue;
        logic commit;
    } stt_cmd_t;

    typedef struct packed {
        logic last_issue;
        logic pipe_busy;
        logic out_free;
    } stt_sts_t;

endpackage

`default_nettype wire

### src/stt_req_if.sv
// Request channel: operation, session id, new token and current time.
`default_nettype none

interface stt_req_if;
    logic                valid;
    logic                ready;
    logic [2:0]          func;
    logic [63:0]         session_id;
    logic [63:0]         new_token;
    logic [47:0]         now_ms;

    modport source (output valid, func, session_id, new_token, now_ms, input ready);
    modport sink   (input valid, func, session_id, new_token, now_ms, output ready);
endinterface

`default_nettype wire

### src/stt_rsp_if.sv
// Response channel: status, token and slot index.
`default_nettype none

interface stt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] token_out;
    logic [2:0]  slot_index;

    modport source (output valid, status, token_out, slot_index, input ready);
    modport sink   (input valid, status, token_out, slot_index, output ready);
endinterface

`default_nettype wire

### src/stt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

`default_nettype wire

### src/stt_datapath.sv
// Datapath: timeout registers, session RAM, used bits, slot walk pipeline and result register.
`default_nettype none

module stt_datapath import stt_pkg::*; #(
    parameter int SESSIONS   = SESSIONS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF,
    parameter int TOKEN_BITS = TOKEN_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire stt_cmd_t              cmd,
    output stt_sts_t                   sts,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic [2:0]            func,
    input  wire logic [FIELD_W-1:0]    session_id,
    input  wire logic [FIELD_W-1:0]    new_token,
    input  wire logic [TIME_W-1:0]     now_ms,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic [1:0]                 status,
    output logic [FIELD_W-1:0]         token_out,
    output logic [2:0]                 slot_index
);
    localparam int IDX_W   = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int ENTRY_W = ID_BITS + TOKEN_BITS + 2 * TIME_W;

    logic [CFG_W-1:0]       idle_tmo_reg;
    logic [CFG_W-1:0]       abs_tmo_reg;

    logic [2:0]             func_reg;
    logic [ID_BITS-1:0]     id_reg;
    logic [TOKEN_BITS-1:0]  tok_reg;
    logic [TIME_W-1:0]      now_reg;

    logic [IDX_W-1:0]       rd_cnt_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic                   rd_vld_reg;

    logic [ENTRY_W-1:0]     rdata;
    logic [ID_BITS-1:0]     e_id;
    logic [TOKEN_BITS-1:0]  e_tok;
    logic [TIME_W-1:0]      e_created;
    logic [TIME_W-1:0]      e_last;

    logic                   a_vld_reg;
    logic                   a_used_reg;
    logic                   a_idm_reg;
    logic [IDX_W-1:0]       a_idx_reg;
    logic [TOKEN_BITS-1:0]  a_tok_reg;
    logic [TIME_W-1:0]      a_created_reg;
    logic [TIME_W:0]        a_dc_reg;
    logic [TIME_W:0]        a_dl_reg;
    logic                   a_exp;
    logic                   a_match;

    logic                   found_reg;
    logic [IDX_W-1:0]       hit_idx_reg;
    logic                   hit_exp_reg;
    logic [TOKEN_BITS-1:0]  hit_tok_reg;
    logic [TIME_W-1:0]      hit_created_reg;

    logic [SESSIONS-1:0]    used_reg;
    logic [SESSIONS-1:0]    used_next;

    logic                   is_create;
    logic                   is_sweep_op;
    logic                   is_lookup;
    logic                   ok_lookup;

    logic                   ram_we;
    logic [ENTRY_W-1:0]     ram_wdata;

    logic [1:0]             res_status;
    logic [FIELD_W-1:0]     res_tok;
    logic [2:0]             res_slot;
    logic [IDX_W+2:0]       slot_ext;

    logic                   out_vld_reg;
    logic [1:0]             status_reg;
    logic [FIELD_W-1:0]     token_reg;
    logic [2:0]             slot_reg;

    // Timeout registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_tmo_reg <= IDLE_TMO_RST;
            abs_tmo_reg  <= ABS_TMO_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDLE_TMO: idle_tmo_reg <= cfg_data;
                CFG_ABS_TMO:  abs_tmo_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the request on transfer
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            func_reg <= func;
            id_reg   <= session_id[ID_BITS-1:0];
            tok_reg  <= new_token[TOKEN_BITS-1:0];
            now_reg  <= now_ms;
        end
    end

    assign is_create   = (func_reg == FN_CREATE);
    assign is_sweep_op = func_reg inside {FN_CREATE, FN_SWEEP};
    assign is_lookup   = func_reg inside {FN_CHECK, FN_TOUCH, FN_REVOKE, FN_READ};
    assign ok_lookup   = found_reg && !hit_exp_reg;

    // Read address walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_cnt_reg <= '0;
            rd_vld_reg <= 1'b0;
            a_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                rd_cnt_reg <= '0;
            end
            else if (cmd.issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + IDX_W'(1);
            end
            rd_vld_reg <= cmd.issue;
            a_vld_reg  <= rd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rd_idx_reg <= rd_cnt_reg;
        end
    end

    stt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SESSIONS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (hit_idx_reg),
        .wdata (ram_wdata),
        .re    (cmd.issue),
        .raddr (rd_cnt_reg),
        .rdata (rdata)
    );

    assign {e_id, e_tok, e_created, e_last} = rdata;

    // Stage A: id compare and time differences, borrow in the top bit
    always_ff @(posedge clk)
    begin
        a_used_reg    <= used_reg[rd_idx_reg];
        a_idm_reg     <= (e_id == id_reg) && (id_reg != '0);
        a_idx_reg     <= rd_idx_reg;
        a_tok_reg     <= e_tok;
        a_created_reg <= e_created;
        a_dc_reg      <= {1'b0, now_reg} - {1'b0, e_created};
        a_dl_reg      <= {1'b0, now_reg} - {1'b0, e_last};
    end

    // Stage B: expiry and match decision
    assign a_exp = !a_used_reg
                 || a_dc_reg[TIME_W] || a_dl_reg[TIME_W]
                 || (a_dc_reg[TIME_W-1:0] >= TIME_W'(abs_tmo_reg))
                 || (a_dl_reg[TIME_W-1:0] >= TIME_W'(idle_tmo_reg));
    assign a_match = a_used_reg && a_idm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            found_reg <= 1'b0;
        end
        else if (a_vld_reg && !found_reg)
        begin
            if ((is_create && a_exp) || (is_lookup && a_match))
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // Hold the first free or expired slot on create, the first id match on lookups
    always_ff @(posedge clk)
    begin
        if (a_vld_reg && !found_reg
            && ((is_create && a_exp) || (is_lookup && a_match)))
        begin
            hit_idx_reg     <= a_idx_reg;
            hit_exp_reg     <= a_exp;
            hit_tok_reg     <= a_tok_reg;
            hit_created_reg <= a_created_reg;
        end
    end

    // Used bits: drop expired records during a create or sweep, then apply the commit
    always_comb
    begin
        used_next = used_reg;
        if (a_vld_reg && is_sweep_op && a_used_reg && a_exp)
        begin
            used_next[a_idx_reg] = 1'b0;
        end
        if (cmd.commit && found_reg)
        begin
            if (is_create)
            begin
                used_next[hit_idx_reg] = 1'b1;
            end
            else if (func_reg == FN_REVOKE)
            begin
                used_next[hit_idx_reg] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    // Entry write on create or touch
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = {id_reg, tok_reg, now_reg, now_reg};
        if (cmd.commit && found_reg)
        begin
            if (is_create)
            begin
                ram_we = 1'b1;
            end
            else if (func_reg == FN_TOUCH && !hit_exp_reg)
            begin
                ram_we    = 1'b1;
                ram_wdata = {id_reg, hit_tok_reg, hit_created_reg, now_reg};
            end
        end
    end

    // Result
    assign slot_ext = (IDX_W + 3)'(hit_idx_reg);

    always_comb
    begin
        res_status = ST_MISS;
        res_tok    = '0;
        res_slot   = '0;
        case (func_reg)
            FN_CREATE:
            begin
                if (found_reg)
                begin
                    res_status = ST_OK;
                    res_tok    = FIELD_W'(tok_reg);
                    res_slot   = slot_ext[2:0];
                end
                else
                begin
                    res_status = ST_FULL;
                end
            end
            FN_CHECK, FN_TOUCH:
            begin
                if (ok_lookup)
                begin
                    res_status = ST_OK;
                    res_slot   = slot_ext[2:0];
                end
            end
            FN_READ:
            begin
                if (ok_lookup)
                begin
                    res_status = ST_OK;
                    res_tok    = FIELD_W'(hit_tok_reg);
                    res_slot   = slot_ext[2:0];
                end
            end
            FN_REVOKE:
            begin
                if (found_reg)
                begin
                    res_status = ST_OK;
                    res_slot   = slot_ext[2:0];
                end
            end
            FN_SWEEP:
            begin
                res_status = ST_OK;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg <= res_status;
            token_reg  <= res_tok;
            slot_reg   <= res_slot;
        end
    end

    assign out_valid  = out_vld_reg;
    assign status     = status_reg;
    assign token_out  = token_reg;
    assign slot_index = slot_reg;

    assign sts.last_issue = (rd_cnt_reg == IDX_W'(SESSIONS - 1));
    assign sts.pipe_busy  = rd_vld_reg || a_vld_reg;
    assign sts.out_free   = !out_vld_reg || out_ready;
endmodule

`default_nettype wire

### src/stt_ctrl.sv
// Controller: sequences request capture, slot walk, pipeline drain and commit.
`default_nettype none

module stt_ctrl import stt_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire stt_sts_t  sts,
    output stt_cmd_t       cmd
);
    stt_state_t state_reg;
    stt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.issue = 1'b1;
                if (sts.last_issue)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                // hold until the result register can take the result
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

`default_nettype wire

### src/session_table_with_timeouts.sv
// Session table with idle and absolute timeouts: top level.
// Each request walks all SESSIONS slots through the single read port of the
// session RAM, one slot per cycle, with a two-stage compare pipeline behind it;
// the next request can be taken in the cycle after the previous result is
// committed. The result sits in an output register, so a new request is taken
// while the previous result waits.
// Used marks live in flip-flops cleared by reset; no clearing pass is needed.
// The user must write timeouts through cfg_we/cfg_index/cfg_data only while
// idle; the block itself does not enforce this.
`default_nettype none

module session_table_with_timeouts import stt_pkg::*; #(
    parameter int SESSIONS   = SESSIONS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF,
    parameter int TOKEN_BITS = TOKEN_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    stt_req_if.sink                    req,
    stt_rsp_if.source                  rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);
    stt_cmd_t cmd;
    stt_sts_t sts;

    stt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    stt_datapath #(
        .SESSIONS   (SESSIONS),
        .ID_BITS    (ID_BITS),
        .TOKEN_BITS (TOKEN_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .func       (req.func),
        .session_id (req.session_id),
        .new_token  (req.new_token),
        .now_ms     (req.now_ms),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .status     (rsp.status),
        .token_out  (rsp.token_out),
        .slot_index (rsp.slot_index)
    );

    // One request in flight: no transfer right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while another is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.status == ST_OK || rsp.status == ST_FULL
                       || rsp.status == ST_MISS))
        else $error("illegal status code");

    // Failed requests carry no token and no slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> (rsp.token_out == '0 && rsp.slot_index == '0))
        else $error("failure result with nonzero token or slot");

    // A sweep result never carries a token
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && u_dp.func_reg == FN_SWEEP) |=> (rsp.token_out == '0))
        else $error("sweep result with nonzero token");
endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking bench for the session table: predicts every response and compares each field.
`default_nettype none

module tb;
    import stt_pkg::*;

    // Function codes the block leaves undefined
    localparam logic [2:0] FN_UNDEF_LO = 3'd6;
    localparam logic [2:0] FN_UNDEF_HI = 3'd7;

    localparam int POOL = 12;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] token;
        logic [2:0]  slot;
    } reply_t;

    class session_shadow;
        bit                used [SESSIONS_DEF];
        logic [63:0]       sid  [SESSIONS_DEF];
        logic [63:0]       tok  [SESSIONS_DEF];
        logic [TIME_W-1:0] born [SESSIONS_DEF];
        logic [TIME_W-1:0] seen [SESSIONS_DEF];
        logic [CFG_W-1:0]  idle_tmo;
        logic [CFG_W-1:0]  abs_tmo;
        reply_t            expected_replies [$];
        int                mismatches;
        int                requests;
        int                responses;
        int                n_created;
        int                n_full;
        int                n_miss;

        function new();
            for (int k = 0; k < SESSIONS_DEF; k++)
                drop_slot(k);
            idle_tmo   = IDLE_TMO_RST;
            abs_tmo    = ABS_TMO_RST;
            mismatches = 0;
            requests   = 0;
            responses  = 0;
            n_created  = 0;
            n_full     = 0;
            n_miss     = 0;
        endfunction

        function void drop_slot(int k);
            used[k] = 1'b0;
            sid[k]  = '0;
            tok[k]  = '0;
            born[k] = '0;
            seen[k] = '0;
        endfunction

        function bit stale(int k, logic [TIME_W-1:0] now);
            if (!used[k])
                return 1'b1;
            // a clock that ran backwards past either stamp expires the record
            if (now < born[k] || now < seen[k])
                return 1'b1;
            if (now - born[k] >= {16'd0, abs_tmo})
                return 1'b1;
            return (now - seen[k] >= {16'd0, idle_tmo});
        endfunction

        function int lookup(logic [63:0] id);
            if (id == 64'd0)
                return -1;
            for (int k = 0; k < SESSIONS_DEF; k++)
                if (used[k] && sid[k] == id)
                    return k;
            return -1;
        endfunction

        function void purge(logic [TIME_W-1:0] now);
            for (int k = 0; k < SESSIONS_DEF; k++)
                if (used[k] && stale(k, now))
                    drop_slot(k);
        endfunction

        function void set_timeout(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_IDLE_TMO)
                idle_tmo = val;
            else
                abs_tmo = val;
        endfunction

        function void note_request(logic [2:0] fn, logic [63:0] id, logic [63:0] token,
                                   logic [TIME_W-1:0] now);
            reply_t r;
            int     hit;
            r.status = ST_MISS;
            r.token  = '0;
            r.slot   = '0;
            requests++;
            case (fn)
                FN_CREATE:
                begin
                    purge(now);
                    r.status = ST_FULL;
                    for (int k = 0; k < SESSIONS_DEF; k++)
                    begin
                        if (!used[k])
                        begin
                            used[k]  = 1'b1;
                            sid[k]   = id;
                            tok[k]   = token;
                            born[k]  = now;
                            seen[k]  = now;
                            r.status = ST_OK;
                            r.token  = token;
                            r.slot   = 3'(k);
                            break;
                        end
                    end
                end
                FN_CHECK, FN_TOUCH, FN_READ:
                begin
                    hit = lookup(id);
                    if (hit >= 0 && !stale(hit, now))
                    begin
                        r.status = ST_OK;
                        r.slot   = 3'(hit);
                        if (fn == FN_TOUCH)
                            seen[hit] = now;
                        if (fn == FN_READ)
                            r.token = tok[hit];
                    end
                end
                FN_REVOKE:
                begin
                    // clear the match even when it has already expired
                    hit = lookup(id);
                    if (hit >= 0)
                    begin
                        drop_slot(hit);
                        r.status = ST_OK;
                        r.slot   = 3'(hit);
                    end
                end
                FN_SWEEP:
                begin
                    purge(now);
                    r.status = ST_OK;
                end
                default: ;
            endcase
            if (fn == FN_CREATE && r.status == ST_OK)
                n_created++;
            if (r.status == ST_FULL)
                n_full++;
            if (r.status == ST_MISS)
                n_miss++;
            expected_replies.push_back(r);
        endfunction

        function void check_response(logic [1:0] status, logic [63:0] token, logic [2:0] slot);
            reply_t e;
            responses++;
            if (expected_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response with no request pending: status %0d token %h slot %0d",
                             status, token, slot);
                return;
            end
            e = expected_replies.pop_front();
            if (e.status !== status || e.token !== token || e.slot !== slot)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch %0d: expected status %0d token %h slot %0d, got status %0d token %h slot %0d",
                             mismatches, e.status, e.token, e.slot, status, token, slot);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    bit                gaps_on;
    logic [TIME_W-1:0] clock_ms;
    logic [63:0]       id_pool [POOL];
    int                settings_used;
    session_shadow     shadow;

    stt_req_if req_ch ();
    stt_rsp_if rsp_ch ();

    session_table_with_timeouts dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // Response side: check each transfer, then pick the next ready value
    initial
    begin
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                shadow.check_response(rsp_ch.status, rsp_ch.token_out, rsp_ch.slot_index);
            rsp_ch.ready <= !(gaps_on && $urandom_range(99) < 35);
        end
    end

    task automatic send_request(logic [2:0] fn, logic [63:0] id, logic [63:0] token,
                                logic [TIME_W-1:0] now);
        while (gaps_on && $urandom_range(99) < 35)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= fn;
        req_ch.session_id <= id;
        req_ch.new_token  <= token;
        req_ch.now_ms     <= now;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        shadow.note_request(fn, id, token, now);
    endtask

    // Drop valid, wait for every pending response, then let the pipeline empty
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (shadow.expected_replies.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_timeouts(logic [CFG_W-1:0] idle, logic [CFG_W-1:0] abs);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDLE_TMO;
        cfg_data  <= idle;
        @(posedge clk);
        cfg_index <= CFG_ABS_TMO;
        cfg_data  <= abs;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow.set_timeout(CFG_IDLE_TMO, idle);
        shadow.set_timeout(CFG_ABS_TMO, abs);
        settings_used++;
    endtask

    task automatic random_request(int unsigned max_step);
        int                roll;
        logic [2:0]        fn;
        logic [63:0]       id;
        logic [63:0]       wide;
        logic [TIME_W-1:0] now;
        roll = $urandom_range(99);
        if (roll < 85)
        begin
            // well-formed traffic: known ids on a clock that only moves forward
            clock_ms = clock_ms + 48'($urandom_range(max_step));
            roll = $urandom_range(99);
            if (roll < 25)
                fn = FN_CREATE;
            else if (roll < 45)
                fn = FN_CHECK;
            else if (roll < 65)
                fn = FN_TOUCH;
            else if (roll < 75)
                fn = FN_REVOKE;
            else if (roll < 90)
                fn = FN_READ;
            else
                fn = FN_SWEEP;
            id  = id_pool[$urandom_range(POOL - 1)];
            now = clock_ms;
        end
        else
        begin
            fn = 3'($urandom_range(7));
            case ($urandom_range(2))
                0:       id = '0;
                1:       id = {$urandom, $urandom};
                default: id = id_pool[$urandom_range(POOL - 1)];
            endcase
            wide = {$urandom, $urandom};
            if ($urandom_range(1) == 0)
                now = wide[TIME_W-1:0];
            else
                now = clock_ms - 48'($urandom_range(50));
        end
        wide = {$urandom, $urandom};
        send_request(fn, id, wide, now);
    endtask

    task automatic run_phase(logic [CFG_W-1:0] idle, logic [CFG_W-1:0] abs,
                             logic [TIME_W-1:0] start_ms, int unsigned max_step,
                             int count, int calm);
        settle();
        write_timeouts(idle, abs);
        clock_ms = start_ms;
        for (int k = 0; k < POOL; k++)
            id_pool[k] = {$urandom, $urandom};
        for (int n = 0; n < count; n++)
        begin
            // hold both sides busy-free for the first calm transfers
            gaps_on = (n >= calm);
            random_request(max_step);
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        logic [63:0] sid_a;
        shadow            = new();
        settings_used     = 0;
        gaps_on           = 1'b1;
        clock_ms          = '0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_IDLE_TMO;
        cfg_data          = '0;
        req_ch.valid      = 1'b0;
        req_ch.func       = FN_SWEEP;
        req_ch.session_id = '0;
        req_ch.new_token  = '0;
        req_ch.now_ms     = '0;
        sid_a             = 64'h0123_4567_89AB_CDEF;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_timeouts(32'd100, 32'd1000);
        send_request(FN_CREATE, sid_a, 64'h1111_2222_3333_4444, 48'd1000);
        send_request(FN_CREATE, 64'd0, '1, 48'd1000);
        send_request(FN_CREATE, '1, 64'd0, 48'd1000);
        send_request(FN_CHECK, sid_a, 64'd0, 48'd1050);
        send_request(FN_CHECK, 64'd0, 64'd0, 48'd1050);
        send_request(FN_TOUCH, sid_a, 64'd0, 48'd1090);
        send_request(FN_READ, sid_a, 64'd0, 48'd1150);
        send_request(FN_READ, '1, 64'd0, 48'd1150);
        send_request(FN_REVOKE, '1, 64'd0, 48'd1150);
        // duplicate id: sweeps the zero-id record and lands in its slot
        send_request(FN_CREATE, sid_a, 64'h5555_6666_7777_8888, 48'd1150);
        send_request(FN_CHECK, sid_a, 64'd0, 48'd1160);
        send_request(FN_CHECK, sid_a, 64'd0, 48'd999);
        for (int k = 1; k <= 6; k++)
            send_request(FN_CREATE, sid_a + 64'(k), 64'(k) << 40, 48'd1160);
        send_request(FN_CREATE, 64'hDEAD_BEEF, 64'hAAAA, 48'd1160);
        send_request(FN_UNDEF_LO, sid_a, 64'hFFFF, 48'd1160);
        send_request(FN_UNDEF_HI, sid_a, 64'hFFFF, 48'd1160);
        send_request(FN_SWEEP, 64'd0, 64'd0, 48'd1160);
        send_request(FN_TOUCH, sid_a, 64'd0, 48'd1200);
        send_request(FN_REVOKE, 64'h1234, 64'd0, 48'd1200);
        send_request(FN_SWEEP, 64'd0, 64'd0, '1);

        run_phase(IDLE_TMO_RST, ABS_TMO_RST, 48'd5_000_000, 2000, 150, 0);
        run_phase(32'd1, 32'd1, 48'd77, 1, 100, 0);
        run_phase('1, '1, 48'h8000_0000_0000, 32'h4000_0000, 150, 0);
        run_phase(32'd40, 32'd300, 48'd1000, 30, 200, 120);
        run_phase(32'd500, 32'd250, 48'd0, 60, 150, 0);
        run_phase(32'($urandom_range(1000, 1)), 32'($urandom_range(5000, 1)),
                  48'd123456, 80, 200, 0);
        settle();

        $display("covered %0d requests under %0d timeout settings: %0d sessions opened, %0d refused on a full table, %0d lookups missed or expired",
                 shadow.requests, settings_used, shadow.n_created, shadow.n_full, shadow.n_miss);
        $display("compared %0d responses, %0d mismatches", shadow.responses, shadow.mismatches);
        if (shadow.mismatches == 0 && shadow.expected_replies.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
